FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the color converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/rycc_pkg.sv
// Package with types, coefficient tables and constants of the color converter.
`default_nettype none
package rycc_pkg;

  localparam int COEF_FRAC_BITS = 16;

  // Coefficient magnitude stays below 2, so F+2 signed bits hold it.
  localparam int CoefW = COEF_FRAC_BITS + 2;
  localparam int OpW   = 9;
  localparam int ProdW = CoefW + OpW;
  localparam int AccW  = COEF_FRAC_BITS + 12;
  localparam int NumComp = 3;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_REV = 1'b1
  } dir_e;

  typedef logic signed [OpW-1:0]   operand_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  typedef operand_t op_arr_t [NumComp];
  typedef prod_t    prod_row_t [NumComp];
  typedef prod_row_t prod_mat_t [NumComp];
  typedef acc_t     acc_arr_t [NumComp];
  typedef logic [7:0] pix_arr_t [NumComp];
  typedef coef_t    coef_row_t [NumComp];
  typedef coef_row_t coef_mat_t [NumComp];

  // Constant given in units of 1/10000, scaled by 2^F, rounded half up on magnitude.
  function automatic coef_t coef(input longint tt);
    longint mag;
    longint c;
    mag = (tt < 0) ? -tt : tt;
    c = ((mag <<< COEF_FRAC_BITS) + 64'sd5000) / 64'sd10000;
    return (tt < 0) ? coef_t'(-c) : coef_t'(c);
  endfunction

  localparam coef_t CoefOne  = coef_t'(longint'(1) <<< COEF_FRAC_BITS);
  localparam coef_t CoefZero = coef_t'(0);

  localparam coef_mat_t FwdCoef = '{
    '{coef(2990),  coef(5870),  coef(1140)},
    '{coef(-1687), coef(-3313), coef(5000)},
    '{coef(5000),  coef(-4187), coef(-813)}
  };

  // Reverse rows take Y through a unit coefficient.
  localparam coef_mat_t RevCoef = '{
    '{CoefOne, CoefZero,    coef(14020)},
    '{CoefOne, coef(-3441), coef(-7141)},
    '{CoefOne, coef(17720), CoefZero}
  };

  localparam acc_t ChromaOffset = acc_t'(longint'(128) <<< COEF_FRAC_BITS);
  localparam acc_t RoundHalf    = acc_t'(longint'(1) <<< (COEF_FRAC_BITS - 1));
  localparam acc_t PixMax       = acc_t'(255);

endpackage
`default_nettype wire

FILE: sv/rycc_operand_stage.sv
// First pipeline stage: register the pixel and form signed multiplier operands.
`default_nettype none
module rycc_operand_stage
  import rycc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire logic     valid_i,
  input  wire dir_e     dir_i,
  input  wire logic [7:0] comp_first_i,
  input  wire logic [7:0] comp_second_i,
  input  wire logic [7:0] comp_third_i,
  output logic          valid_o,
  output dir_e          dir_o,
  output op_arr_t       op_o
);

  logic    valid_q;
  dir_e    dir_q;
  op_arr_t op_q, op_d;

  always_comb begin
    op_d[0] = operand_t'({1'b0, comp_first_i});
    if (dir_i == DIR_REV) begin
      // Center chroma around zero.
      op_d[1] = operand_t'({1'b0, comp_second_i}) - operand_t'(128);
      op_d[2] = operand_t'({1'b0, comp_third_i}) - operand_t'(128);
    end else begin
      op_d[1] = operand_t'({1'b0, comp_second_i});
      op_d[2] = operand_t'({1'b0, comp_third_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      dir_q <= dir_i;
      op_q  <= op_d;
    end
  end

  assign valid_o = valid_q;
  assign dir_o   = dir_q;
  assign op_o    = op_q;

endmodule
`default_nettype wire

FILE: sv/rycc_mult_stage.sv
// Second pipeline stage: nine coefficient products and the row offsets.
`default_nettype none
module rycc_mult_stage
  import rycc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    advance_i,
  input  wire logic    valid_i,
  input  wire dir_e    dir_i,
  input  wire op_arr_t op_i,
  output logic         valid_o,
  output prod_mat_t    prod_o,
  output acc_arr_t     off_o
);

  logic      valid_q;
  prod_mat_t prod_q, prod_d;
  acc_arr_t  off_q, off_d;

  always_comb begin
    for (int r = 0; r < NumComp; r++) begin
      for (int k = 0; k < NumComp; k++) begin
        if (dir_i == DIR_REV) begin
          prod_d[r][k] = prod_t'(op_i[k]) * prod_t'(RevCoef[r][k]);
        end else begin
          prod_d[r][k] = prod_t'(op_i[k]) * prod_t'(FwdCoef[r][k]);
        end
      end
    end
    off_d[0] = acc_t'(0);
    off_d[1] = (dir_i == DIR_FWD) ? ChromaOffset : acc_t'(0);
    off_d[2] = (dir_i == DIR_FWD) ? ChromaOffset : acc_t'(0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q <= prod_d;
      off_q  <= off_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;
  assign off_o   = off_q;

endmodule
`default_nettype wire

FILE: sv/rycc_sum_stage.sv
// Third pipeline stage: add the three products and the offset of each row.
`default_nettype none
module rycc_sum_stage
  import rycc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire logic      valid_i,
  input  wire prod_mat_t prod_i,
  input  wire acc_arr_t  off_i,
  output logic           valid_o,
  output acc_arr_t       acc_o
);

  logic     valid_q;
  acc_arr_t acc_q, acc_d;

  always_comb begin
    for (int r = 0; r < NumComp; r++) begin
      acc_d[r] = acc_t'(prod_i[r][0]) + acc_t'(prod_i[r][1])
               + acc_t'(prod_i[r][2]) + off_i[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;

endmodule
`default_nettype wire

FILE: sv/rycc_round_sat.sv
// Last pipeline stage: round, saturate to 0..255 and hold the output item.
`default_nettype none
module rycc_round_sat
  import rycc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     advance_i,
  input  wire logic     valid_i,
  input  wire acc_arr_t acc_i,
  output logic          valid_o,
  output pix_arr_t      pix_o
);

  logic     valid_q;
  pix_arr_t pix_q, pix_d;
  acc_arr_t rnd;

  // A negative sum rounds to zero or below, so it always clamps to 0.
  always_comb begin
    for (int r = 0; r < NumComp; r++) begin
      rnd[r] = (acc_i[r] + RoundHalf) >>> COEF_FRAC_BITS;
      if (acc_i[r] < 0) begin
        pix_d[r] = 8'd0;
      end else if (rnd[r] > PixMax) begin
        pix_d[r] = 8'd255;
      end else begin
        pix_d[r] = rnd[r][7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule
`default_nettype wire

FILE: sv/rgb_ycbcr_color_converter_unit.sv
// Top level of the RGB / full-range YCbCr color converter pipeline.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one pixel of three 8-bit
//   components; the output channel (out_valid_o / out_ready_i) returns one
//   converted pixel per input pixel, in order.
//   cfg_we_i writes cfg_wdata_i into the direction register: 0 converts
//   RGB to YCbCr (chroma offset 128), 1 converts YCbCr back to RGB. Write
//   it only while the pipeline is empty; each item samples it on entry.
//   Throughput: one pixel per clock unless the receiver stalls; four register stages (operands,
//   products, sums, round and saturate) all advance together.
//   Reset clears every stage valid bit and sets direction to RGB to YCbCr.
//   When the receiver stalls, the whole pipeline holds and in_ready_o
//   drops; while the output register is empty every stage advances,
//   so no item is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module rgb_ycbcr_color_converter_unit
  import rycc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] comp_first_i,
  input  wire logic [7:0] comp_second_i,
  input  wire logic [7:0] comp_third_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_first_o,
  output logic [7:0]      out_second_o,
  output logic [7:0]      out_third_o
);

  dir_e      dir_q;
  logic      advance;
  logic      s1_valid, s2_valid, s3_valid;
  dir_e      s1_dir;
  op_arr_t   s1_op;
  prod_mat_t s2_prod;
  acc_arr_t  s2_off;
  acc_arr_t  s3_acc;
  pix_arr_t  pix;

  // Direction register: only bit 0 of the written value exists.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_FWD;
    end else if (cfg_we_i) begin
      dir_q <= dir_e'(cfg_wdata_i);
    end
  end

  // Advance every stage when the output register is free or being taken.
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  rycc_operand_stage u_operand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .valid_i       (in_valid_i),
    .dir_i         (dir_q),
    .comp_first_i  (comp_first_i),
    .comp_second_i (comp_second_i),
    .comp_third_i  (comp_third_i),
    .valid_o       (s1_valid),
    .dir_o         (s1_dir),
    .op_o          (s1_op)
  );

  rycc_mult_stage u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (s1_valid),
    .dir_i     (s1_dir),
    .op_i      (s1_op),
    .valid_o   (s2_valid),
    .prod_o    (s2_prod),
    .off_o     (s2_off)
  );

  rycc_sum_stage u_sum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (s2_valid),
    .prod_i    (s2_prod),
    .off_i     (s2_off),
    .valid_o   (s3_valid),
    .acc_o     (s3_acc)
  );

  rycc_round_sat u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (s3_valid),
    .acc_i     (s3_acc),
    .valid_o   (out_valid_o),
    .pix_o     (pix)
  );

  assign out_first_o  = pix[0];
  assign out_second_o = pix[1];
  assign out_third_o  = pix[2];

  // An accepted item reaches the output when the receiver keeps ready.
  `ASSERT_RST(a_latency,
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o,
    "accepted item did not reach the output in four cycles")

  // The first stage fills only through an input accept.
  `ASSERT_RST(a_s1_fill, $rose(s1_valid) |-> $past(in_valid_i && in_ready_o),
    "first stage became valid without an accepted item")

  // Reset empties the pipeline.
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o || !$past(rst_ni, 3),
    "output valid too soon after reset")

endmodule
`default_nettype wire
